// File: src/intel_hex_loader_macros.svh
// assertion macros for the intel hex loader
// used by the top level; no other dependencies
`ifndef INTEL_HEX_LOADER_MACROS_SVH
`define INTEL_HEX_LOADER_MACROS_SVH

// same-cycle implication, disabled during reset
`define IHL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define IHL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/ihl_pkg.sv
// shared types, codes and the nibble decode for the intel hex loader
// no dependencies
`default_nettype none

package ihl_pkg;

   // ascii codes
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] NIBBLE_TEN = 8'd10;

   // record types
   localparam logic [7:0] REC_DATA = 8'h00;
   localparam logic [7:0] REC_EOF  = 8'h01;

   // header byte positions
   localparam logic [1:0] HEAD_LEN     = 2'd0;
   localparam logic [1:0] HEAD_ADDR_HI = 2'd1;
   localparam logic [1:0] HEAD_ADDR_LO = 2'd2;
   localparam logic [1:0] HEAD_TYPE    = 2'd3;

   // result kinds
   localparam logic [2:0] KIND_WRITE    = 3'd0;
   localparam logic [2:0] KIND_OK       = 3'd1;
   localparam logic [2:0] KIND_SUM_ERR  = 3'd2;
   localparam logic [2:0] KIND_TYPE_ERR = 3'd3;
   localparam logic [2:0] KIND_EARLY    = 3'd4;

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_HEADER,
      PH_DATA,
      PH_CHECK
   } phase_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_START,
      OP_HEAD,
      OP_DATA,
      OP_CHECK,
      OP_OK,
      OP_TYPE_ERR
   } op_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       text_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] write_address;
      logic [7:0]  write_data;
   } rsp_type;

   // token passed from front to back
   typedef struct packed {
      op_type     op;
      logic [1:0] head_idx;
      logic [7:0] value;
      logic       text_end;
   } tok_type;

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] v;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = c - CH_ZERO;
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         v = c - CH_UPPER_A + NIBBLE_TEN;
      end else begin
         v = c - CH_LOWER_A + NIBBLE_TEN;
      end
      return v[3:0];
   endfunction

endpackage

`default_nettype wire

// File: src/ihl_front.sv
// front end: takes characters, pairs nibbles into bytes, tracks record layout
// depends on ihl_pkg
`default_nettype none

module ihl_front import ihl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    tok_valid,
   input  logic    tok_ready,
   output tok_type tok_data
);

   phase_type  phase_ff, phase_in;
   logic       held_ff, held_in;
   logic [3:0] nib_ff, nib_in;
   logic [1:0] hcount_ff, hcount_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] dcount_ff, dcount_in;
   logic       done_ff, done_in;

   logic [3:0] nib_cur;
   logic [7:0] byte_val;
   logic [7:0] dcount_next;
   logic       take;
   logic       push;
   op_type     op;

   assign nib_cur     = nibble_of(req_data.char_code);
   assign byte_val    = {nib_ff, nib_cur};
   assign dcount_next = dcount_ff + 8'd1;

   // once done, characters are swallowed
   assign req_ready = done_ff | tok_ready;
   assign take      = req_valid & tok_ready & ~done_ff;

   // next state
   always_comb begin
      phase_in  = phase_ff;
      held_in   = held_ff;
      nib_in    = nib_ff;
      hcount_in = hcount_ff;
      len_in    = len_ff;
      dcount_in = dcount_ff;
      done_in   = done_ff;
      if (take) begin
         if (phase_ff == PH_WAIT) begin
            if (req_data.char_code == CH_COLON) begin
               phase_in  = PH_HEADER;
               held_in   = 1'b0;
               hcount_in = HEAD_LEN;
               dcount_in = 8'd0;
            end
         end else if (!held_ff) begin
            nib_in  = nib_cur;
            held_in = 1'b1;
         end else begin
            held_in = 1'b0;
            unique case (phase_ff)
               PH_HEADER: begin
                  if (hcount_ff == HEAD_LEN) begin
                     len_in = byte_val;
                  end
                  if (hcount_ff != HEAD_TYPE) begin
                     hcount_in = hcount_ff + 2'd1;
                  end else begin
                     hcount_in = HEAD_LEN;
                     if (byte_val == REC_DATA) begin
                        phase_in = (len_ff != 8'd0) ? PH_DATA : PH_CHECK;
                     end else begin
                        done_in = 1'b1;
                     end
                  end
               end
               PH_DATA: begin
                  dcount_in = dcount_next;
                  if (dcount_next == len_ff) begin
                     phase_in = PH_CHECK;
                  end
               end
               PH_CHECK: begin
                  phase_in = PH_WAIT;
               end
               PH_WAIT: begin
                  phase_in = PH_WAIT;
               end
            endcase
         end
         if (req_data.text_end) begin
            done_in = 1'b1;
         end
      end
   end

   // token output
   always_comb begin
      push = 1'b0;
      op   = OP_IDLE;
      unique case (phase_ff)
         PH_WAIT: begin
            if (req_data.char_code == CH_COLON) begin
               push = 1'b1;
               op   = OP_START;
            end
         end
         PH_HEADER: begin
            if (held_ff) begin
               push = 1'b1;
               op   = OP_HEAD;
               if (hcount_ff == HEAD_TYPE && byte_val != REC_DATA) begin
                  op = (byte_val == REC_EOF) ? OP_OK : OP_TYPE_ERR;
               end
            end
         end
         PH_DATA: begin
            if (held_ff) begin
               push = 1'b1;
               op   = OP_DATA;
            end
         end
         PH_CHECK: begin
            if (held_ff) begin
               push = 1'b1;
               op   = OP_CHECK;
            end
         end
      endcase
      if (req_data.text_end) begin
         push = 1'b1;
      end
   end

   assign tok_valid         = req_valid & ~done_ff & push;
   assign tok_data.op       = op;
   assign tok_data.head_idx = hcount_ff;
   assign tok_data.value    = byte_val;
   assign tok_data.text_end = req_data.text_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         held_ff   <= 1'b0;
         hcount_ff <= HEAD_LEN;
         dcount_ff <= 8'd0;
         done_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         hcount_ff <= hcount_in;
         dcount_ff <= dcount_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      nib_ff <= nib_in;
      len_ff <= len_in;
   end

endmodule

`default_nettype wire

// File: src/ihl_queue.sv
// short token queue between the front and back ends
// depends on ihl_pkg
`default_nettype none

module ihl_queue import ihl_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  tok_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output tok_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   tok_type         entries_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: src/ihl_back.sv
// back end: address and checksum tracking, result register
// depends on ihl_pkg
`default_nettype none

module ihl_back import ihl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    tok_valid,
   output logic    tok_ready,
   input  tok_type tok_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic        finished_ff, finished_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  off_ff, off_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;

   logic        pop;
   logic        emit;
   logic        finish;
   logic [7:0]  sum_neg;
   rsp_type     rsp_in;

   assign tok_ready = ~rsp_valid_ff | rsp_ready;
   assign pop       = tok_valid & tok_ready;
   assign sum_neg   = 8'd0 - sum_ff;

   always_comb begin
      addr_in = addr_ff;
      sum_in  = sum_ff;
      off_in  = off_ff;
      emit    = 1'b0;
      finish  = 1'b0;
      rsp_in  = '{kind: KIND_WRITE, write_address: 16'd0, write_data: 8'd0};
      if (pop && !finished_ff) begin
         unique case (tok_data.op)
            OP_START: begin
               sum_in = 8'd0;
               off_in = 8'd0;
            end
            OP_HEAD: begin
               sum_in = sum_ff + tok_data.value;
               if (tok_data.head_idx == HEAD_ADDR_HI) begin
                  addr_in[15:8] = tok_data.value;
               end
               if (tok_data.head_idx == HEAD_ADDR_LO) begin
                  addr_in[7:0] = tok_data.value;
               end
            end
            OP_DATA: begin
               emit                 = 1'b1;
               rsp_in.kind          = KIND_WRITE;
               rsp_in.write_address = addr_ff + 16'(off_ff);
               rsp_in.write_data    = tok_data.value;
               sum_in               = sum_ff + tok_data.value;
               off_in               = off_ff + 8'd1;
            end
            OP_CHECK: begin
               if (sum_neg != tok_data.value) begin
                  emit        = 1'b1;
                  finish      = 1'b1;
                  rsp_in.kind = KIND_SUM_ERR;
               end
            end
            OP_OK: begin
               emit        = 1'b1;
               finish      = 1'b1;
               rsp_in.kind = KIND_OK;
            end
            OP_TYPE_ERR: begin
               emit        = 1'b1;
               finish      = 1'b1;
               rsp_in.kind = KIND_TYPE_ERR;
            end
            OP_IDLE: begin
               emit = 1'b0;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
         // text end overrides a write from the same character
         if (!finish && tok_data.text_end) begin
            emit        = 1'b1;
            finish      = 1'b1;
            rsp_in.kind = KIND_EARLY;
         end
         if (rsp_in.kind != KIND_WRITE) begin
            rsp_in.write_address = 16'd0;
            rsp_in.write_data    = 8'd0;
         end
      end
      finished_in  = finished_ff | finish;
      rsp_valid_in = emit | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         finished_ff  <= 1'b0;
         addr_ff      <= 16'd0;
         sum_ff       <= 8'd0;
         off_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         finished_ff  <= finished_in;
         addr_ff      <= addr_in;
         sum_ff       <= sum_in;
         off_ff       <= off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: src/intel_hex_loader.sv
// intel hex loader top level: front end, token queue, back end
// depends on ihl_pkg, ihl_front, ihl_queue, ihl_back, intel_hex_loader_macros.svh
//
// usage:
//   req channel carries one ascii character per transfer (char_code) and a
//   text_end flag that marks the last character of the text
//   rsp channel carries zero or one result per character: a byte write
//   (address and data) for each data byte, or one terminal result (load ok,
//   checksum error, unsupported record type, text ended early)
//   a character may be taken every cycle; the front end pairs nibbles and
//   tracks record layout, the back end tracks address, offset and checksum
//   a character that yields a token has it written into the token queue as it is
//   taken; the back end later pops it into the result register behind rsp_valid
//   throughput: one character per cycle while req_ready stays high, set by the
//   front end state update and the queue pop into the result register
//   receiver stall: the result register holds, the queue fills, and req_ready
//   drops once the queue is full; nothing is dropped
//   after a terminal result every character is accepted and ignored
//   reset (synchronous, active high) returns to waiting for a colon and
//   empties the queue and result register
`default_nettype none

`include "intel_hex_loader_macros.svh"

module intel_hex_loader import ihl_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // front to queue
   logic    fq_valid;
   logic    fq_ready;
   tok_type fq_data;

   // queue to back
   logic    qb_valid;
   logic    qb_ready;
   tok_type qb_data;

   ihl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .tok_valid (fq_valid),
      .tok_ready (fq_ready),
      .tok_data  (fq_data)
   );

   ihl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   ihl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (qb_valid),
      .tok_ready (qb_ready),
      .tok_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // result-side conditions watched by the assertions
   logic term_xfer;
   logic rsp_term;
   logic term_clear;
   logic kind_known;

   assign term_xfer  = rsp_valid & rsp_ready & (rsp_data.kind != KIND_WRITE);
   assign rsp_term   = rsp_valid & (rsp_data.kind != KIND_WRITE);
   assign term_clear = (rsp_data.write_address == 16'd0) & (rsp_data.write_data == 8'd0);
   assign kind_known = rsp_data.kind inside {KIND_WRITE, KIND_OK, KIND_SUM_ERR,
                                             KIND_TYPE_ERR, KIND_EARLY};

   // nothing follows the transfer of a terminal result
   `IHL_ASSERT_NEXT(a_quiet_after_end, clock, reset, term_xfer, !rsp_valid, "result after end")

   // only writes carry address and data
   `IHL_ASSERT_NOW(a_terminal_zero, clock, reset, rsp_term, term_clear, "terminal payload")

   // kind stays within the defined codes
   `IHL_ASSERT_NOW(a_kind_range, clock, reset, rsp_valid, kind_known, "undefined result kind")

endmodule

`default_nettype wire

// File: dv/ihl_checker.sv
// result checker for the intel hex loader: predicts every result from accepted characters
// and compares what the block returns; depends on ihl_pkg only
module ihl_checker import ihl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   input  logic    run_over,
   output int      fail_count,
   output int      pending,
   output int      writes_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   phase_type  phase;
   logic       nib_held;
   logic [3:0] nib_hi;
   logic [1:0] head_pos;
   logic [7:0] rec_len;
   logic [15:0] rec_addr;
   logic [7:0] rec_type;
   logic [7:0] offset;
   logic [7:0] sum;
   logic       load_done;

   rsp_type awaited_results[$];

   initial begin
      fail_count  = 0;
      pending     = 0;
      writes_seen = 0;
   end

   task automatic report(input string msg);
      $display("%0t ihl_checker: %s", $realtime, msg);
      fail_count++;
   endtask

   // digits map straight through; any other code lands on its low nibble plus nine
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return c[3:0];
      return c[3:0] + 4'd9;
   endfunction

   task automatic load_char(input req_type r);
      logic [7:0] b;
      rsp_type    res;
      bit         has;
      has = 1'b0;
      res = '0;
      if (load_done) return;
      if (phase == PH_WAIT) begin
         if (r.char_code == CH_COLON) begin
            phase    = PH_HEADER;
            nib_held = 1'b0;
            head_pos = HEAD_LEN;
            offset   = '0;
            sum      = '0;
         end
      end else if (!nib_held) begin
         nib_hi   = hex_value(r.char_code);
         nib_held = 1'b1;
      end else begin
         b        = {nib_hi, hex_value(r.char_code)};
         nib_held = 1'b0;
         case (phase)
            PH_HEADER: begin
               sum = sum + b;
               case (head_pos)
                  HEAD_LEN:     rec_len = b;
                  HEAD_ADDR_HI: rec_addr[15:8] = b;
                  HEAD_ADDR_LO: rec_addr[7:0] = b;
                  default:      rec_type = b;
               endcase
               if (head_pos != HEAD_TYPE) begin
                  head_pos = head_pos + 2'd1;
               end else begin
                  head_pos = HEAD_LEN;
                  if (rec_type == REC_DATA) begin
                     phase = (rec_len != 8'd0) ? PH_DATA : PH_CHECK;
                  end else if (rec_type == REC_EOF) begin
                     has       = 1'b1;
                     res.kind  = KIND_OK;
                     load_done = 1'b1;
                  end else begin
                     has       = 1'b1;
                     res.kind  = KIND_TYPE_ERR;
                     load_done = 1'b1;
                  end
               end
            end
            PH_DATA: begin
               has               = 1'b1;
               res.kind          = KIND_WRITE;
               res.write_address = rec_addr + {8'h00, offset};
               res.write_data    = b;
               sum               = sum + b;
               offset            = offset + 8'd1;
               if (offset == rec_len) phase = PH_CHECK;
            end
            default: begin
               // checksum byte closes the record when it cancels the running sum
               if (b == 8'h00 - sum) begin
                  phase = PH_WAIT;
               end else begin
                  has       = 1'b1;
                  res.kind  = KIND_SUM_ERR;
                  load_done = 1'b1;
               end
            end
         endcase
      end
      if (!load_done && r.text_end) begin
         has       = 1'b1;
         res       = '0;
         res.kind  = KIND_EARLY;
         load_done = 1'b1;
      end
      if (has) awaited_results.push_back(res);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         phase     = PH_WAIT;
         nib_held  = 1'b0;
         nib_hi    = '0;
         head_pos  = HEAD_LEN;
         rec_len   = '0;
         rec_addr  = '0;
         rec_type  = '0;
         offset    = '0;
         sum       = '0;
         load_done = 1'b0;
         awaited_results.delete();
      end else begin
         if (req_valid && req_ready) load_char(req_data);
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report($sformatf("unexpected result kind %0d addr %h data %h",
                  rsp_data.kind, rsp_data.write_address, rsp_data.write_data));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.kind != want.kind)
                  report($sformatf("kind %0d, wanted %0d", rsp_data.kind, want.kind));
               if (rsp_data.write_address != want.write_address)
                  report($sformatf("write_address %h, wanted %h",
                     rsp_data.write_address, want.write_address));
               if (rsp_data.write_data != want.write_data)
                  report($sformatf("write_data %h, wanted %h",
                     rsp_data.write_data, want.write_data));
            end
            if (rsp_data.kind == KIND_WRITE) writes_seen++;
         end
      end
      pending = awaited_results.size();
   end

   always @(posedge run_over) begin
      if (awaited_results.size() != 0)
         report($sformatf("%0d results never arrived", awaited_results.size()));
   end

endmodule

// File: dv/tb_intel_hex_loader.sv
// top of the intel hex loader testbench: builds a hex text stream, drives it with
// random gaps and stalls, and gives the verdict; depends on ihl_pkg, ihl_checker and intel_hex_loader
module tb_intel_hex_loader import ihl_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 10;
   localparam int LONG_HOLD    = 60;     // receiver hold-off, enough to fill the token queue
   localparam int DRAIN_LIMIT  = 2000;
   localparam int SETTLE       = 20;     // wait after the drain before the final check
   localparam int TEXT_BUDGET  = 1100;   // record characters, directed records included, before the ending
   localparam int TIMEOUT_NS   = 400000;

   // how the single load of this run is brought to an end
   typedef enum int {
      END_EOF,
      END_SUM,
      END_TYPE,
      END_IN_RECORD,
      END_IN_GAP
   } ending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    run_over = 1'b0;
   int      fail_count;
   int      pending;
   int      writes_seen;

   // shared between the stimulus and the receiver
   bit quiet = 1'b0;
   int hold_req = 0;

   // the whole text, built up front, and the data bytes of the record being built
   req_type    stream[$];
   logic [7:0] rec_data[$];
   int         rec_hi[$];
   int         rec_count = 0;
   int         record_chars = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   intel_hex_loader dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ihl_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .run_over    (run_over),
      .fail_count  (fail_count),
      .pending     (pending),
      .writes_seen (writes_seen)
   );

   // character that decodes to nibble n: digit or letter of either case, or a raw
   // code whose upper half is hi (random when hi is negative)
   function automatic logic [7:0] char_for(input logic [3:0] n, input int hi);
      logic [3:0] top4;
      logic [3:0] low4;
      int         style;
      style = (hi < 0) ? int'($urandom_range(0, 2)) : 2;
      if (style < 2 && n < 4'd10) return CH_ZERO + {4'h0, n};
      if (style == 0) return CH_UPPER_A + {4'h0, n} - NIBBLE_TEN;
      if (style == 1) return CH_LOWER_A + {4'h0, n} - NIBBLE_TEN;
      // outside the digits a code decodes as its low nibble plus nine
      low4 = n + 4'd7;
      top4 = (hi < 0) ? 4'($urandom_range(0, 15)) : hi[3:0];
      // keep clear of the digit codes
      if (top4 == 4'h3 && low4 < 4'd10) top4 = 4'h6;
      return {top4, low4};
   endfunction

   function automatic logic [7:0] any_but_colon();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CH_COLON);
      return c;
   endfunction

   task automatic add_char(input logic [7:0] c, input logic e);
      req_type item;
      item.char_code = c;
      item.text_end  = e;
      stream.push_back(item);
   endtask

   task automatic add_byte(input logic [7:0] b, input int hi);
      add_char(char_for(b[7:4], hi), 1'b0);
      add_char(char_for(b[3:0], hi), 1'b0);
   endtask

   // junk between records, skipped while waiting for a colon
   task automatic add_noise(input int count);
      repeat (count) add_char(any_but_colon(), 1'b0);
   endtask

   task automatic random_data(input int len);
      rec_data.delete();
      rec_hi.delete();
      repeat (len) begin
         rec_data.push_back(8'($urandom_range(0, 255)));
         rec_hi.push_back(-1);
      end
   endtask

   // one record from rec_data; checksum is the two's complement of the byte sum
   task automatic add_record(input logic [15:0] addr, input logic [7:0] rtype,
                             input bit bad_sum);
      logic [7:0] len;
      logic [7:0] sum;
      logic [7:0] cs;
      len = 8'(rec_data.size());
      sum = len + addr[15:8] + addr[7:0] + rtype;
      add_char(CH_COLON, 1'b0);
      add_byte(len, -1);
      add_byte(addr[15:8], -1);
      add_byte(addr[7:0], -1);
      add_byte(rtype, -1);
      foreach (rec_data[k]) begin
         add_byte(rec_data[k], rec_hi[k]);
         sum = sum + rec_data[k];
      end
      cs = 8'h00 - sum;
      if (bad_sum) cs = cs + 8'($urandom_range(1, 255));
      add_byte(cs, -1);
      rec_count++;
      record_chars += 2 * (5 + len) + 1;
   endtask

   // one transfer on the request side; entered and left at a falling edge
   task automatic send_char(input req_type item);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin : receiver
      int hold_done;
      int burst;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_done != hold_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_done++;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 7);
            rsp_ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int         n;
      int         w;
      int         start;
      int         idx;
      int         len;
      logic [15:0] addr;
      ending_type ending;

      // directed: code 0 and 255 skipped between records, then the same codes
      // and a colon taken as digits inside a record that wraps past ffff
      add_char(8'h00, 1'b0);
      add_char(8'hFF, 1'b0);
      rec_data = '{8'h88, 8'h99, 8'h33};
      rec_hi   = '{15, 0, 3};
      add_record(16'hFFFE, REC_DATA, 1'b0);
      // empty data record goes straight to its checksum
      random_data(0);
      add_record(16'($urandom_range(0, 65535)), REC_DATA, 1'b0);

      // random well-formed data records, mostly short, some near the top of memory
      while (record_chars < TEXT_BUDGET) begin
         add_noise($urandom_range(0, 3));
         len  = ($urandom_range(0, 29) == 0) ? $urandom_range(17, 255) : $urandom_range(0, 16);
         addr = ($urandom_range(0, 4) == 0) ? 16'hFFFF - 16'($urandom_range(0, 15))
                                             : 16'($urandom_range(0, 65535));
         random_data(len);
         add_record(addr, REC_DATA, 1'b0);
      end

      // the load ends exactly once per run; the seed picks how
      add_noise($urandom_range(0, 3));
      ending = ending_type'($urandom_range(0, 4));
      start  = stream.size();
      case (ending)
         END_EOF: begin
            random_data(0);
            add_record(16'($urandom_range(0, 65535)), REC_EOF, 1'b0);
            // text end on the type byte itself still reports success
            if ($urandom_range(0, 1) == 1) stream[start + 8].text_end = 1'b1;
         end
         END_SUM: begin
            random_data($urandom_range(1, 8));
            add_record(16'($urandom_range(0, 65535)), REC_DATA, 1'b1);
         end
         END_TYPE: begin
            random_data($urandom_range(0, 4));
            add_record(16'($urandom_range(0, 65535)), 8'($urandom_range(2, 255)), 1'b0);
         end
         END_IN_RECORD: begin
            random_data($urandom_range(1, 8));
            add_record(16'($urandom_range(0, 65535)), REC_DATA, 1'b0);
            // half the time on a character that would have completed a write
            idx = ($urandom_range(0, 1) == 1) ? start + 10
                                               : $urandom_range(start, stream.size() - 1);
            stream[idx].text_end = 1'b1;
         end
         default: begin
            add_char(any_but_colon(), 1'b1);
         end
      endcase
      // everything after the end is accepted and ignored
      repeat ($urandom_range(8, 16))
         add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      n = stream.size();
      for (int i = 0; i < n; i++) begin
         // calm stretch mid-run and no idling at all near the end
         quiet = (i >= n - n / 8) || (i >= n * 3 / 5 && i < n * 7 / 10);
         if (i == n / 4) hold_req++;
         if (i == n / 2) begin
            // hold the sender until the block has handed back everything
            req_valid <= 1'b0;
            do @(negedge clock); while (pending != 0);
         end
         send_char(stream[i]);
      end
      req_valid <= 1'b0;

      w = 0;
      while (pending != 0 && w < DRAIN_LIMIT) begin
         @(negedge clock);
         w++;
      end
      repeat (SETTLE) @(negedge clock);
      run_over <= 1'b1;
      @(negedge clock);

      $display("tb_intel_hex_loader: %0d characters, %0d records, %0d byte writes, ended by %s",
         n, rec_count, writes_seen, ending.name());
      $display("tb_intel_hex_loader: random gaps and stalls, one long hold-off, one drain pause");
      if (fail_count == 0) begin
         $display("tb_intel_hex_loader: done, clean");
      end else begin
         $display("tb_intel_hex_loader: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("tb_intel_hex_loader: done, errors");
      $finish;
   end

endmodule
